/* sv/acwc_pkg.sv */
// Package: shared constants, codes, state types and control structs of the congestion controller.
package acwc_pkg;

    // Default widths
    localparam int SEQ_WIDTH_DEF    = 32;
    localparam int WINDOW_WIDTH_DEF = 16;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Counter widths
    localparam int CNT_W     = 32;
    localparam int CNT_IDX_W = $clog2(CNT_W);
    localparam int DUP_W     = 3;
    localparam int RUN_W     = 5;

    // Duplicate ack and timeout run limits
    localparam logic [DUP_W-1:0] DUP_TRIGGER = 3'd3;
    localparam logic [DUP_W-1:0] DUP_SAT     = 3'd4;
    localparam logic [RUN_W-1:0] GIVE_UP_RUN = 5'd20;
    localparam int               DUP_FLOOR   = 2;
    localparam int               FR_INFLATE  = 3;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_TH_RST   = 16'd16;
    localparam logic [CFG_W-1:0] MAX_WIN_RST  = 16'd128;
    localparam logic [CFG_W-1:0] INIT_WIN_RST = 16'd1;
    localparam logic [CFG_W-1:0] INIT_TH_RST  = 16'd64;

    typedef enum logic [1:0] {
        PH_SS = 2'd0,
        PH_CA = 2'd1,
        PH_FR = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_TH   = 2'd0,
        CFG_MAX_WIN  = 2'd1,
        CFG_INIT_WIN = 2'd2,
        CFG_INIT_TH  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_COMMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic div_start;
        logic div_step;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_status;

endpackage

/* sv/acwc_if.sv */
// Interfaces: event input channel, result output channel and configuration write channel.
interface acwc_evt_if #(
    parameter int SEQ_WIDTH = acwc_pkg::SEQ_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [SEQ_WIDTH-1:0] ack_number;
    logic                 handshake_ack;

    modport source (output valid, action, ack_number, handshake_ack, input ready);
    modport sink   (input valid, action, ack_number, handshake_ack, output ready);
endinterface

interface acwc_res_if #(
    parameter int SEQ_WIDTH    = acwc_pkg::SEQ_WIDTH_DEF,
    parameter int WINDOW_WIDTH = acwc_pkg::WINDOW_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [WINDOW_WIDTH-1:0] window_size;
    logic [WINDOW_WIDTH-1:0] threshold;
    logic [1:0]              phase;
    logic [SEQ_WIDTH-1:0]    window_start;
    logic                    retransmit_valid;
    logic [SEQ_WIDTH-1:0]    retransmit_seq;
    logic                    give_up;

    modport source (output valid, window_size, threshold, phase, window_start,
                    retransmit_valid, retransmit_seq, give_up, input ready);
    modport sink   (input valid, window_size, threshold, phase, window_start,
                    retransmit_valid, retransmit_seq, give_up, output ready);
endinterface

interface acwc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [acwc_pkg::CFG_IDX_W-1:0] index;
    logic [acwc_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/ack_congestion_window_control_unit.sv */
// Top level: congestion window controller with config registers, controller and datapath.
// Flow: an accepted item is evaluated and committed to the output register; a new ack in
// congestion avoidance first runs a 32-step serial remainder unit to check divisibility.
// A new item is taken in only after the last one is committed; commit waits on a stall.
// A finished result waits in the output register while the next item is taken in.
// Reset: synchronous, active low; state, config and output valid return to their defaults.
module ack_congestion_window_control_unit #(
    parameter int SEQ_WIDTH    = acwc_pkg::SEQ_WIDTH_DEF,
    parameter int WINDOW_WIDTH = acwc_pkg::WINDOW_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    acwc_evt_if.sink   i_evt,
    acwc_res_if.source o_res,
    acwc_cfg_if.sink   i_cfg
);
    import acwc_pkg::*;

    logic [CFG_W-1:0] r_min_th;
    logic [CFG_W-1:0] r_max_win;
    t_cmd             cmd;
    t_status          status;

    // Configuration writes; the initial values act only through reset
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_th  <= MIN_TH_RST;
            r_max_win <= MAX_WIN_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index)) inside
                CFG_MIN_TH:                r_min_th  <= i_cfg.data;
                CFG_MAX_WIN:               r_max_win <= i_cfg.data;
                CFG_INIT_WIN, CFG_INIT_TH: ;
                default: ;
            endcase
        end
    end

    acwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    acwc_dp #(
        .SEQ_WIDTH    (SEQ_WIDTH),
        .WINDOW_WIDTH (WINDOW_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_action           (i_evt.action),
        .i_ack_number       (i_evt.ack_number),
        .i_handshake_ack    (i_evt.handshake_ack),
        .i_min_threshold    (r_min_th),
        .i_max_window       (r_max_win),
        .o_window_size      (o_res.window_size),
        .o_threshold        (o_res.threshold),
        .o_phase            (o_res.phase),
        .o_window_start     (o_res.window_start),
        .o_retransmit_valid (o_res.retransmit_valid),
        .o_retransmit_seq   (o_res.retransmit_seq),
        .o_give_up          (o_res.give_up)
    );

endmodule

/* sv/acwc_ctrl.sv */
// Controller: runs one item through evaluate, optional serial remainder and commit, owns output valid.
module acwc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  acwc_pkg::t_status i_status,
    output acwc_pkg::t_cmd    o_cmd
);
    import acwc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        out_free   = !r_out_valid || i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/acwc_dp.sv */
// Datapath: controller state, serial remainder unit, next-state logic and output register.
module acwc_dp #(
    parameter int SEQ_WIDTH    = acwc_pkg::SEQ_WIDTH_DEF,
    parameter int WINDOW_WIDTH = acwc_pkg::WINDOW_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  acwc_pkg::t_cmd             i_cmd,
    output acwc_pkg::t_status          o_status,
    input  logic                       i_action,
    input  logic [SEQ_WIDTH-1:0]       i_ack_number,
    input  logic                       i_handshake_ack,
    input  logic [acwc_pkg::CFG_W-1:0] i_min_threshold,
    input  logic [acwc_pkg::CFG_W-1:0] i_max_window,
    output logic [WINDOW_WIDTH-1:0]    o_window_size,
    output logic [WINDOW_WIDTH-1:0]    o_threshold,
    output logic [1:0]                 o_phase,
    output logic [SEQ_WIDTH-1:0]       o_window_start,
    output logic                       o_retransmit_valid,
    output logic [SEQ_WIDTH-1:0]       o_retransmit_seq,
    output logic                       o_give_up
);
    import acwc_pkg::*;

    // Compare width: holds window, registers and sums without overflow
    localparam int XW = ((WINDOW_WIDTH > CFG_W) ? WINDOW_WIDTH : CFG_W) + 2;
    localparam int BW = ((SEQ_WIDTH > XW) ? SEQ_WIDTH : XW) + 1;
    localparam logic [BW-1:0] WMAX_X       = {{(BW-WINDOW_WIDTH){1'b0}}, {WINDOW_WIDTH{1'b1}}};
    localparam logic [BW-1:0] DUP_FLOOR_X  = BW'(DUP_FLOOR);
    localparam logic [BW-1:0] FR_INFLATE_X = BW'(FR_INFLATE);
    localparam logic [BW-1:0] ONE_X        = BW'(1);

    // Saturate to the window width
    function automatic logic [WINDOW_WIDTH-1:0] sat(input logic [BW-1:0] v);
        return (v > WMAX_X) ? {WINDOW_WIDTH{1'b1}} : v[WINDOW_WIDTH-1:0];
    endfunction

    // Controller state
    t_phase                  r_phase;
    logic [WINDOW_WIDTH-1:0] r_window;
    logic [WINDOW_WIDTH-1:0] r_thresh;
    logic [DUP_W-1:0]        r_dup;
    logic [SEQ_WIDTH-1:0]    r_acked;
    logic [CNT_W-1:0]        r_inc;
    logic [RUN_W-1:0]        r_run;

    // Latched item
    logic                    r_timeout;
    logic [SEQ_WIDTH-1:0]    r_ack;
    logic                    r_hs;

    // Serial remainder unit
    logic [CNT_W-1:0]        r_dvd;
    logic [WINDOW_WIDTH-1:0] r_rem;
    logic [CNT_IDX_W-1:0]    r_div_cnt;
    logic [WINDOW_WIDTH:0]   rem_shift;
    logic [WINDOW_WIDTH:0]   rem_sub;

    // Output register
    t_phase                  r_o_phase;
    logic [WINDOW_WIDTH-1:0] r_o_window;
    logic [WINDOW_WIDTH-1:0] r_o_thresh;
    logic [SEQ_WIDTH-1:0]    r_o_start;
    logic                    r_o_rvalid;
    logic [SEQ_WIDTH-1:0]    r_o_rseq;
    logic                    r_o_gup;

    // Next state
    t_phase                  n_phase;
    logic [BW-1:0]           n_win_x;
    logic [WINDOW_WIDTH-1:0] n_thresh;
    logic [DUP_W-1:0]        n_dup;
    logic [SEQ_WIDTH-1:0]    n_acked;
    logic [CNT_W-1:0]        n_inc;
    logic [RUN_W-1:0]        n_run;
    logic                    n_rvalid;
    logic [SEQ_WIDTH-1:0]    n_rseq;
    logic                    n_gup;

    logic [BW-1:0]           win_x;
    logic [BW-1:0]           half_x;
    logic [BW-1:0]           min_x;
    logic [BW-1:0]           max_x;
    logic [BW-1:0]           diff_x;
    logic [BW-1:0]           th_x;
    logic [BW-1:0]           infl_x;
    logic                    ack_eq;
    logic                    ack_gt;
    logic                    divisible;

    assign win_x     = BW'(r_window);
    assign half_x    = win_x >> 1;
    assign min_x     = BW'(i_min_threshold);
    assign max_x     = BW'(i_max_window);
    assign diff_x    = BW'(r_ack - r_acked);
    assign ack_eq    = (r_ack == r_acked);
    assign ack_gt    = (r_ack > r_acked);
    assign divisible = (r_window == '0) || (r_rem == '0);

    // Remainder needed only for a new ack in congestion avoidance with a nonzero window
    always_comb begin
        o_status.need_div = !r_timeout && !r_hs && ack_gt && (r_phase != PH_SS)
                            && (r_phase != PH_FR) && (r_window != '0);
        o_status.div_last = (r_div_cnt == CNT_IDX_W'(CNT_W - 1));
    end

    // One restoring remainder step
    assign rem_shift = {r_rem, r_dvd[CNT_W-1]};
    assign rem_sub   = rem_shift - {1'b0, r_window};

    // Evaluate the event against the current state
    always_comb begin
        n_phase  = r_phase;
        n_win_x  = win_x;
        n_thresh = r_thresh;
        n_dup    = r_dup;
        n_acked  = r_acked;
        n_inc    = r_inc;
        n_run    = r_run;
        n_rvalid = 1'b0;
        n_rseq   = '0;
        n_gup    = 1'b0;
        th_x     = '0;
        infl_x   = '0;

        if (r_timeout) begin
            // timeout: halve with floor and request a resend, or give up
            n_run = (r_run < GIVE_UP_RUN) ? r_run + 1'b1 : r_run;
            if (n_run >= GIVE_UP_RUN) begin
                n_gup = 1'b1;
            end else begin
                th_x     = (half_x < min_x) ? min_x : half_x;
                n_thresh = sat(th_x);
                n_win_x  = BW'(n_thresh);
                n_dup    = '0;
                n_rvalid = 1'b1;
                n_rseq   = r_acked + 1'b1;
            end
        end else begin
            n_run = '0;
            if (!r_hs) begin
                if (ack_eq) begin
                    // duplicate ack
                    if (r_phase == PH_FR) begin
                        if (win_x < max_x) begin
                            n_win_x = BW'(sat(win_x + ONE_X));
                        end
                    end else begin
                        n_dup = (r_dup < DUP_SAT) ? r_dup + 1'b1 : r_dup;
                        if (n_dup == DUP_TRIGGER) begin
                            th_x     = (half_x < DUP_FLOOR_X) ? DUP_FLOOR_X : half_x;
                            n_thresh = sat(th_x);
                            infl_x   = BW'(sat(BW'(n_thresh) + FR_INFLATE_X));
                            n_win_x  = (win_x > infl_x) ? win_x : infl_x;
                            n_phase  = PH_FR;
                        end
                    end
                end else if (ack_gt) begin
                    // new ack: update the window by phase and slide the acked number
                    n_dup = '0;
                    case (r_phase)
                        PH_SS: begin
                            if (win_x < max_x) begin
                                n_win_x = BW'(sat(win_x + diff_x));
                            end
                            if (n_win_x > BW'(r_thresh)) begin
                                n_phase = PH_CA;
                            end
                        end
                        PH_FR: begin
                            n_phase = PH_CA;
                            infl_x  = BW'(sat(BW'(r_thresh) + FR_INFLATE_X));
                            n_win_x = (infl_x > min_x) ? infl_x : min_x;
                        end
                        default: begin
                            n_inc = r_inc + 1'b1;
                            if (divisible) begin
                                n_win_x = BW'(sat(win_x + ONE_X));
                            end
                        end
                    endcase
                    n_acked = r_ack;
                end
            end
        end

        // cap the window
        if (n_win_x > max_x) begin
            n_win_x = max_x;
        end
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SS;
            r_window  <= WINDOW_WIDTH'(INIT_WIN_RST);
            r_thresh  <= WINDOW_WIDTH'(INIT_TH_RST);
            r_dup     <= '0;
            r_acked   <= '0;
            r_inc     <= '0;
            r_run     <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.commit) begin
                r_phase  <= n_phase;
                r_window <= n_win_x[WINDOW_WIDTH-1:0];
                r_thresh <= n_thresh;
                r_dup    <= n_dup;
                r_acked  <= n_acked;
                r_inc    <= n_inc;
                r_run    <= n_run;
            end
        end
    end

    // Item latch, remainder unit and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_timeout <= i_action;
            r_ack     <= i_ack_number;
            r_hs      <= i_handshake_ack;
        end
        if (i_cmd.div_start) begin
            r_dvd <= r_inc + 1'b1;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= rem_sub[WINDOW_WIDTH] ? rem_shift[WINDOW_WIDTH-1:0]
                                            : rem_sub[WINDOW_WIDTH-1:0];
        end
        if (i_cmd.commit) begin
            r_o_phase  <= n_phase;
            r_o_window <= n_win_x[WINDOW_WIDTH-1:0];
            r_o_thresh <= n_thresh;
            r_o_start  <= n_acked + 1'b1;
            r_o_rvalid <= n_rvalid;
            r_o_rseq   <= n_rseq;
            r_o_gup    <= n_gup;
        end
    end

    assign o_window_size      = r_o_window;
    assign o_threshold        = r_o_thresh;
    assign o_phase            = r_o_phase;
    assign o_window_start     = r_o_start;
    assign o_retransmit_valid = r_o_rvalid;
    assign o_retransmit_seq   = r_o_rseq;
    assign o_give_up          = r_o_gup;

endmodule

/* sv/acwc_checker.sv */
// Checker: port-level properties of the congestion controller results, bound to the top level.
module acwc_checker #(
    parameter int SEQ_WIDTH = acwc_pkg::SEQ_WIDTH_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input logic [SEQ_WIDTH-1:0] i_window_start,
    input logic                 i_retransmit_valid,
    input logic [SEQ_WIDTH-1:0] i_retransmit_seq,
    input logic                 i_give_up
);

    // A resend and a give up never come from the same item
    a_resend_xor_give_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_retransmit_valid && i_give_up))
        else $error("resend and give up in one item");

    // A timeout leaves the acked number alone, so the resend is the window start
    a_resend_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_retransmit_valid) |-> (i_retransmit_seq == i_window_start))
        else $error("resend sequence differs from window start");

    // Without a resend request the sequence field is zero
    a_resend_seq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_retransmit_valid) |-> (i_retransmit_seq == '0))
        else $error("resend sequence set without a resend");

    // Reset drops any pending item
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_window_start)))
        else $error("stalled item changed");

endmodule

bind ack_congestion_window_control_unit acwc_checker #(
    .SEQ_WIDTH (SEQ_WIDTH)
) u_acwc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_window_start     (o_res.window_start),
    .i_retransmit_valid (o_res.retransmit_valid),
    .i_retransmit_seq   (o_res.retransmit_seq),
    .i_give_up          (o_res.give_up)
);
